FILE: src/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the tracking servo step
// Field widths, register codes, register reset values and the queue entry
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int COORD_IN_W  = 16;
   localparam int COORD_W     = 10;
   localparam int ERR_W       = 11;
   localparam int DIFF_W      = 12;
   localparam int SUM_W       = 16;
   localparam int GAIN_W      = 24;
   localparam int LIMIT_W     = 15;
   localparam int ANGLE_W     = 12;
   localparam int CORR_W      = 16;
   localparam int PROD_W      = 40;
   localparam int ACC_W       = 42;
   localparam int FRAC_W      = 22;
   localparam int QUOT_W      = ACC_W - FRAC_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN      = 3'd0,
      CSR_INTEG_GAIN     = 3'd1,
      CSR_DERIV_GAIN     = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_YAW_MIN        = 3'd4,
      CSR_YAW_MAX        = 3'd5,
      CSR_X_LIMIT        = 3'd6,
      CSR_Y_LIMIT        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       integral_limit;
      logic [ANGLE_W-1:0]       yaw_min;
      logic [ANGLE_W-1:0]       yaw_max;
      logic [COORD_W-1:0]       x_limit;
      logic [COORD_W-1:0]       y_limit;
   } cfg_type;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RESET  = -24'sd125829;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RESET = -24'sd419;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RESET = 24'sd0;
   localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET   = 15'd1600;
   localparam logic [ANGLE_W-1:0] YAW_MIN_RESET          = 12'd1200;
   localparam logic [ANGLE_W-1:0] YAW_MAX_RESET          = 12'd1800;
   localparam logic [COORD_W-1:0] X_LIMIT_RESET          = 10'd620;
   localparam logic [COORD_W-1:0] Y_LIMIT_RESET          = 10'd480;

   // One validated frame waiting for the PID back end
   typedef struct packed {
      logic [COORD_W-1:0]      x_target;
      logic [COORD_W-1:0]      x_actual;
      logic [COORD_W-1:0]      y_target;
      logic [COORD_W-1:0]      y_actual;
      logic signed [ERR_W-1:0] err;
      logic                    stop;
   } frame_type;

endpackage

FILE: src/tps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_req_if: frame request channel
// Valid/ready channel carrying one camera frame per transaction.
// ----------------------------------------------------------------------------
interface tps_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_target;
   logic signed [15:0] y_target;
   logic signed [15:0] x_actual;
   logic signed [15:0] y_actual;
   logic               stop;

   modport source (output valid, x_target, y_target, x_actual, y_actual, stop,
                   input ready);
   modport sink (input valid, x_target, y_target, x_actual, y_actual, stop,
                 output ready);
endinterface

FILE: src/tps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_rsp_if: servo response channel
// Valid/ready channel carrying one servo update per transaction.
// ----------------------------------------------------------------------------
interface tps_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        yaw_angle;
   logic [11:0]        pitch_angle;
   logic signed [15:0] correction;
   logic [9:0]         x_target_used;
   logic [9:0]         x_actual_used;
   logic [9:0]         y_target_used;
   logic [9:0]         y_actual_used;

   modport source (output valid, yaw_angle, pitch_angle, correction,
                   x_target_used, x_actual_used, y_target_used, y_actual_used,
                   input ready);
   modport sink (input valid, yaw_angle, pitch_angle, correction,
                 x_target_used, x_actual_used, y_target_used, y_actual_used,
                 output ready);
endinterface

FILE: src/tps_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_fifo: small register queue
// Decouples front end from back end; one push a cycle unless full, one pop unless empty.
// ----------------------------------------------------------------------------
module tps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and track fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: src/tps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_front: frame validation front end
// Accepts frames, replaces out-of-range coordinates by their last accepted
// value, forms the x error and queues the frame for the back end.
// ----------------------------------------------------------------------------
module tps_front
   import tps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tps_req_if.sink    req,
   input  cfg_type    cfg,
   input  logic       queue_full,
   output logic       queue_push,
   output frame_type  queue_data
);

   logic [COORD_W-1:0] prev_x_target_ff, prev_x_actual_ff;
   logic [COORD_W-1:0] prev_y_target_ff, prev_y_actual_ff;
   logic [COORD_W-1:0] x_target_in, x_actual_in, y_target_in, y_actual_in;

   // Keep a coordinate only when it lies in 1..limit-1
   function automatic logic [COORD_W-1:0] validate(
      input logic signed [COORD_IN_W-1:0] raw,
      input logic [COORD_W-1:0]           limit,
      input logic [COORD_W-1:0]           prev
   );
      logic signed [COORD_IN_W-1:0] lim_s;
      lim_s = $signed({{(COORD_IN_W - COORD_W){1'b0}}, limit});
      if (raw > 0 && raw < lim_s) begin
         return raw[COORD_W-1:0];
      end
      return prev;
   endfunction

   assign req.ready  = !queue_full;
   assign queue_push = req.valid && !queue_full;

   assign x_target_in = validate(req.x_target, cfg.x_limit, prev_x_target_ff);
   assign x_actual_in = validate(req.x_actual, cfg.x_limit, prev_x_actual_ff);
   assign y_target_in = validate(req.y_target, cfg.y_limit, prev_y_target_ff);
   assign y_actual_in = validate(req.y_actual, cfg.y_limit, prev_y_actual_ff);

   // Build the queue entry
   always_comb begin
      queue_data.x_target = x_target_in;
      queue_data.x_actual = x_actual_in;
      queue_data.y_target = y_target_in;
      queue_data.y_actual = y_actual_in;
      queue_data.err      = $signed({1'b0, x_target_in}) - $signed({1'b0, x_actual_in});
      queue_data.stop     = req.stop;
   end

   // Remember accepted coordinates on every transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_target_ff <= '0;
         prev_x_actual_ff <= '0;
         prev_y_target_ff <= '0;
         prev_y_actual_ff <= '0;
      end else if (queue_push) begin
         prev_x_target_ff <= x_target_in;
         prev_x_actual_ff <= x_actual_in;
         prev_y_target_ff <= y_target_in;
         prev_y_actual_ff <= y_actual_in;
      end
   end

endmodule

FILE: src/tps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_back: PID back end
// Pops one frame, runs the three PID products through one shared multiplier,
// then truncates, saturates and updates the angles; stopped frames hold them.
// ----------------------------------------------------------------------------
module tps_back
   import tps_pkg::*;
#(
   parameter int YAW_START   = 1500,
   parameter int PITCH_START = 1500,
   parameter int PITCH_MIN   = 1300,
   parameter int PITCH_MAX   = 1700
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       queue_empty,
   input  frame_type  queue_data,
   output logic       queue_pop,
   tps_rsp_if.source  rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL_I, ST_MUL_D, ST_FIN} state_type;

   state_type                 state_ff;
   logic                      out_valid_ff;
   logic signed [SUM_W-1:0]   error_sum_ff;
   logic signed [ERR_W-1:0]   prior_error_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [ANGLE_W-1:0]        yaw_ff, pitch_ff;
   logic                      stop_ff;
   logic [COORD_W-1:0]        x_target_ff, x_actual_ff, y_target_ff, y_actual_ff;

   logic [ANGLE_W-1:0]        out_yaw_ff, out_pitch_ff;
   logic signed [CORR_W-1:0]  out_corr_ff;
   logic [COORD_W-1:0]        out_xt_ff, out_xa_ff, out_yt_ff, out_ya_ff;

   logic signed [SUM_W:0]     sum_wide, lim_pos, lim_neg, sum_in;
   logic signed [DIFF_W-1:0]  diff_in;
   logic signed [GAIN_W-1:0]  mul_gain;
   logic signed [SUM_W-1:0]   mul_op;
   logic signed [PROD_W-1:0]  product;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [QUOT_W-1:0]  quot;
   logic signed [CORR_W-1:0]  corr_in;
   logic signed [ANGLE_W+5:0] yaw_sum, yaw_lo, yaw_hi, yaw_clamp;
   logic [ANGLE_W-1:0]        yaw_in, pitch_in;
   logic                      out_free;

   assign queue_pop = (state_ff == ST_IDLE) && !queue_empty;
   assign out_free  = !out_valid_ff || rsp.ready;

   // Clamp the running error sum and form the error difference
   always_comb begin
      sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
               + {{(SUM_W + 1 - ERR_W){queue_data.err[ERR_W-1]}}, queue_data.err};
      lim_pos  = $signed({2'b00, cfg.integral_limit});
      lim_neg  = -lim_pos;
      sum_in   = sum_wide;
      if (sum_wide > lim_pos) begin
         sum_in = lim_pos;
      end
      if (sum_in < lim_neg) begin
         sum_in = lim_neg;
      end
      diff_in = {queue_data.err[ERR_W-1], queue_data.err}
              - {prior_error_ff[ERR_W-1], prior_error_ff};
   end

   // Select multiplier operands for the current step
   always_comb begin
      case (state_ff)
         ST_MUL_I: begin
            mul_gain = cfg.integ_gain;
            mul_op   = error_sum_ff;
         end
         ST_MUL_D: begin
            mul_gain = cfg.deriv_gain;
            mul_op   = {{(SUM_W - DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
         end
         default: begin
            mul_gain = cfg.prop_gain;
            mul_op   = {{(SUM_W - ERR_W){queue_data.err[ERR_W-1]}}, queue_data.err};
         end
      endcase
      product = mul_gain * mul_op;
      if (state_ff == ST_IDLE) begin
         acc_in = {{(ACC_W - PROD_W){product[PROD_W-1]}}, product};
      end else begin
         acc_in = acc_ff + {{(ACC_W - PROD_W){product[PROD_W-1]}}, product};
      end
   end

   // Truncate toward zero, saturate, and clamp the angles
   always_comb begin
      quot = acc_ff[ACC_W-1:FRAC_W];
      if (acc_ff[ACC_W-1] && (|acc_ff[FRAC_W-1:0])) begin
         quot = quot + 1'b1;
      end
      if (quot > $signed(QUOT_W'(32767))) begin
         corr_in = 16'sh7FFF;
      end else if (quot < -$signed(QUOT_W'(32768))) begin
         corr_in = 16'sh8000;
      end else begin
         corr_in = quot[CORR_W-1:0];
      end

      yaw_sum = $signed({6'b0, yaw_ff}) + {{2{corr_in[CORR_W-1]}}, corr_in};
      yaw_lo  = $signed({6'b0, cfg.yaw_min});
      yaw_hi  = $signed({6'b0, cfg.yaw_max});
      yaw_clamp = yaw_sum;
      if (yaw_clamp <= yaw_lo) begin
         yaw_clamp = yaw_lo;
      end
      if (yaw_clamp >= yaw_hi) begin
         yaw_clamp = yaw_hi;
      end
      yaw_in = yaw_clamp[ANGLE_W-1:0];

      pitch_in = pitch_ff;
      if (pitch_in <= ANGLE_W'(PITCH_MIN)) begin
         pitch_in = ANGLE_W'(PITCH_MIN);
      end
      if (pitch_in >= ANGLE_W'(PITCH_MAX)) begin
         pitch_in = ANGLE_W'(PITCH_MAX);
      end
   end

   // Sequence the PID steps and hold the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         out_valid_ff   <= 1'b0;
         error_sum_ff   <= '0;
         prior_error_ff <= '0;
         yaw_ff         <= ANGLE_W'(YAW_START);
         pitch_ff       <= ANGLE_W'(PITCH_START);
      end else begin
         // Load a finished result, or drop the one just taken
         if (state_ff == ST_FIN && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (queue_pop) begin
                  stop_ff     <= queue_data.stop;
                  x_target_ff <= queue_data.x_target;
                  x_actual_ff <= queue_data.x_actual;
                  y_target_ff <= queue_data.y_target;
                  y_actual_ff <= queue_data.y_actual;
                  if (queue_data.stop) begin
                     state_ff <= ST_FIN;
                  end else begin
                     error_sum_ff   <= sum_in[SUM_W-1:0];
                     prior_error_ff <= queue_data.err;
                     diff_ff        <= diff_in;
                     acc_ff         <= acc_in;
                     state_ff       <= ST_MUL_I;
                  end
               end
            end
            ST_MUL_I: begin
               acc_ff   <= acc_in;
               state_ff <= ST_MUL_D;
            end
            ST_MUL_D: begin
               acc_ff   <= acc_in;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  out_xt_ff    <= x_target_ff;
                  out_xa_ff    <= x_actual_ff;
                  out_yt_ff    <= y_target_ff;
                  out_ya_ff    <= y_actual_ff;
                  if (stop_ff) begin
                     out_yaw_ff   <= yaw_ff;
                     out_pitch_ff <= pitch_ff;
                     out_corr_ff  <= '0;
                  end else begin
                     yaw_ff       <= yaw_in;
                     pitch_ff     <= pitch_in;
                     out_yaw_ff   <= yaw_in;
                     out_pitch_ff <= pitch_in;
                     out_corr_ff  <= corr_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.yaw_angle     = out_yaw_ff;
   assign rsp.pitch_angle   = out_pitch_ff;
   assign rsp.correction    = out_corr_ff;
   assign rsp.x_target_used = out_xt_ff;
   assign rsp.x_actual_used = out_xa_ff;
   assign rsp.y_target_used = out_yt_ff;
   assign rsp.y_actual_used = out_ya_ff;

endmodule

FILE: src/tracking_pid_servo_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracking_pid_servo_step: yaw tracking servo step
// Validates camera frames, runs an incremental PID with a clamped integral
// on the x error and returns the updated yaw and pitch servo angles.
// ----------------------------------------------------------------------------
// A frame is taken whenever the two-entry queue has room, so a burst of
// frames enters one per cycle. The back end takes a running frame through
// ST_IDLE, ST_MUL_I, ST_MUL_D and ST_FIN (one shared 24x16 multiplier
// computes the proportional, integral and derivative products in turn, then
// a finishing step truncates, saturates and clamps), a stopped frame through
// ST_IDLE and ST_FIN; this sets the sustained rate. Results leave through a
// response register, so the back end keeps working while a finished result
// waits. Configuration writes take effect at once and belong in idle periods.
module tracking_pid_servo_step
   import tps_pkg::*;
#(
   parameter int YAW_START   = 1500,
   parameter int PITCH_START = 1500,
   parameter int PITCH_MIN   = 1300,
   parameter int PITCH_MAX   = 1700
) (
   input  logic                   clock,
   input  logic                   reset,
   tps_req_if.sink                req,
   tps_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg_ff;
   logic      queue_push, queue_pop, queue_full, queue_empty;
   frame_type queue_in, queue_out;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= PROP_GAIN_RESET;
         cfg_ff.integ_gain     <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain     <= DERIV_GAIN_RESET;
         cfg_ff.integral_limit <= INTEGRAL_LIMIT_RESET;
         cfg_ff.yaw_min        <= YAW_MIN_RESET;
         cfg_ff.yaw_max        <= YAW_MAX_RESET;
         cfg_ff.x_limit        <= X_LIMIT_RESET;
         cfg_ff.y_limit        <= Y_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROP_GAIN:      cfg_ff.prop_gain      <= csr_data[GAIN_W-1:0];
            CSR_INTEG_GAIN:     cfg_ff.integ_gain     <= csr_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:     cfg_ff.deriv_gain     <= csr_data[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_data[LIMIT_W-1:0];
            CSR_YAW_MIN:        cfg_ff.yaw_min        <= csr_data[ANGLE_W-1:0];
            CSR_YAW_MAX:        cfg_ff.yaw_max        <= csr_data[ANGLE_W-1:0];
            CSR_X_LIMIT:        cfg_ff.x_limit        <= csr_data[COORD_W-1:0];
            CSR_Y_LIMIT:        cfg_ff.y_limit        <= csr_data[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_in)
   );

   tps_fifo #(
      .WIDTH ($bits(frame_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   tps_back #(
      .YAW_START   (YAW_START),
      .PITCH_START (PITCH_START),
      .PITCH_MIN   (PITCH_MIN),
      .PITCH_MAX   (PITCH_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .queue_data  (queue_out),
      .queue_pop   (queue_pop),
      .rsp         (rsp)
   );

endmodule

FILE: src/tps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_checker: port-level assertions for the tracking servo step
// Watches both channels of the top level and checks reset idling, that every
// response has a request open, capacity, stall stability and the pitch clamp.
// ----------------------------------------------------------------------------
module tps_checker
   import tps_pkg::*;
#(
   parameter int PITCH_START = 1500,
   parameter int PITCH_MIN   = 1300,
   parameter int PITCH_MAX   = 1700
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [11:0]        rsp_yaw,
   input logic [11:0]        rsp_pitch,
   input logic signed [15:0] rsp_corr
);

   localparam int MAX_OPEN = QUEUE_DEPTH + 2;
   localparam int OPEN_W   = $clog2(MAX_OPEN + 2);

   logic [OPEN_W-1:0] open_ff;
   logic              req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Count transactions taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else if (req_fire && !rsp_fire) begin
         open_ff <= open_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         open_ff <= open_ff - 1'b1;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != '0)
      else $error("response without a pending request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OPEN_W'(MAX_OPEN))
      else $error("more transactions in flight than the block can hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw)
                                  && $stable(rsp_pitch) && $stable(rsp_corr))
      else $error("stalled response changed");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch == 12'(PITCH_START) || rsp_pitch == 12'(PITCH_MAX)
                    || (rsp_pitch >= 12'(PITCH_MIN) && rsp_pitch <= 12'(PITCH_MAX)))
      else $error("pitch angle outside its clamp");

endmodule

bind tracking_pid_servo_step tps_checker #(
   .PITCH_START (PITCH_START),
   .PITCH_MIN   (PITCH_MIN),
   .PITCH_MAX   (PITCH_MAX)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_yaw   (rsp.yaw_angle),
   .rsp_pitch (rsp.pitch_angle),
   .rsp_corr  (rsp.correction)
);

FILE: verif/tracking_pid_servo_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracking_pid_servo_step_tb: self-checking bench for the yaw tracking step
// Sends camera frames through the request channel under random idling on
// both sides. A local model of the coordinate screening, the clamped PID and
// the servo angle clamps predicts every servo update, and each response is
// compared field by field with the oldest prediction. Register settings are
// changed only while the block is idle.
// ----------------------------------------------------------------------------
module tracking_pid_servo_step_tb;
   import tps_pkg::*;

   localparam int YAW_START   = 1500;
   localparam int PITCH_START = 1500;
   localparam int PITCH_MIN   = 1300;
   localparam int PITCH_MAX   = 1700;

   localparam int CLOCK_HALF       = 10;
   localparam int RESET_CYCLES     = 4;
   localparam int DRAIN_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int NUM_REGS         = 8;
   localparam int NUM_PHASES       = 8;
   localparam int FRAMES_PER_PHASE = 150;
   localparam int SAT_FRAMES       = 15;

   localparam longint ACC_SCALE = longint'(1) << FRAC_W;
   localparam int     CORR_MAX  = 32767;
   localparam int     CORR_MIN  = -32768;

   localparam logic signed [GAIN_W-1:0] GAIN_MAX        = 24'sh7FFFFF;
   localparam logic signed [GAIN_W-1:0] GAIN_MIN        = 24'sh800000;
   localparam logic [LIMIT_W-1:0]       SUM_LIMIT_MAX   = '1;
   localparam logic [ANGLE_W-1:0]       ANGLE_MAX       = '1;
   localparam logic [COORD_W-1:0]       COORD_LIMIT_MAX = '1;

   typedef struct packed {
      logic signed [COORD_IN_W-1:0] x_target;
      logic signed [COORD_IN_W-1:0] y_target;
      logic signed [COORD_IN_W-1:0] x_actual;
      logic signed [COORD_IN_W-1:0] y_actual;
      logic                         stop;
   } frame_in_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]       yaw_angle;
      logic [ANGLE_W-1:0]       pitch_angle;
      logic signed [CORR_W-1:0] correction;
      logic [COORD_W-1:0]       x_target_used;
      logic [COORD_W-1:0]       x_actual_used;
      logic [COORD_W-1:0]       y_target_used;
      logic [COORD_W-1:0]       y_actual_used;
   } servo_out_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   tps_req_if req_if ();
   tps_rsp_if rsp_if ();

   tracking_pid_servo_step #(
      .YAW_START   (YAW_START),
      .PITCH_START (PITCH_START),
      .PITCH_MIN   (PITCH_MIN),
      .PITCH_MAX   (PITCH_MAX)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Local copy of the register settings and the servo loop state
   cfg_type            settings;
   logic [COORD_W-1:0] held_x_target;
   logic [COORD_W-1:0] held_y_target;
   logic [COORD_W-1:0] held_x_actual;
   logic [COORD_W-1:0] held_y_actual;
   int                 error_sum;
   int                 prior_err;
   logic [ANGLE_W-1:0] yaw_pos;
   logic [ANGLE_W-1:0] pitch_pos;

   servo_out_type pending_updates[$];
   int            mismatch_count = 0;
   bit            no_idle = 1'b0;
   int            ready_hold;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic cfg_type reset_settings();
      cfg_type c;
      c.prop_gain      = PROP_GAIN_RESET;
      c.integ_gain     = INTEG_GAIN_RESET;
      c.deriv_gain     = DERIV_GAIN_RESET;
      c.integral_limit = INTEGRAL_LIMIT_RESET;
      c.yaw_min        = YAW_MIN_RESET;
      c.yaw_max        = YAW_MAX_RESET;
      c.x_limit        = X_LIMIT_RESET;
      c.y_limit        = Y_LIMIT_RESET;
      return c;
   endfunction

   // Keep a coordinate only when it lies in 1..limit-1, else reuse the last one
   function automatic logic [COORD_W-1:0] screen_coord(logic signed [COORD_IN_W-1:0] raw,
                                                       logic [COORD_W-1:0] limit,
                                                       logic [COORD_W-1:0] last);
      if (int'(raw) >= 1 && int'(raw) < int'(limit))
         return raw[COORD_W-1:0];
      return last;
   endfunction

   // Advance the servo loop by one frame and return the update it produces
   function automatic servo_out_type servo_update(frame_in_type f);
      servo_out_type r;
      int            err;
      int            lim;
      int            sum;
      longint        acc;
      longint        q;
      int            yaw;
      int            pitch;
      held_x_target = screen_coord(f.x_target, settings.x_limit, held_x_target);
      held_y_target = screen_coord(f.y_target, settings.y_limit, held_y_target);
      held_x_actual = screen_coord(f.x_actual, settings.x_limit, held_x_actual);
      held_y_actual = screen_coord(f.y_actual, settings.y_limit, held_y_actual);
      r.correction = '0;
      if (!f.stop) begin
         err = int'(held_x_target) - int'(held_x_actual);
         lim = int'(settings.integral_limit);
         sum = error_sum + err;
         if (sum > lim)
            sum = lim;
         if (sum < -lim)
            sum = -lim;
         error_sum = sum;
         acc = longint'($signed(settings.prop_gain)) * err
             + longint'($signed(settings.integ_gain)) * sum
             + longint'($signed(settings.deriv_gain)) * (err - prior_err);
         prior_err = err;
         // truncate toward zero, then clip to the correction width
         q = acc / ACC_SCALE;
         if (q > CORR_MAX)
            q = CORR_MAX;
         if (q < CORR_MIN)
            q = CORR_MIN;
         r.correction = q[CORR_W-1:0];
         // low bound first, high bound last
         yaw = int'(yaw_pos) + int'(q);
         if (yaw <= int'(settings.yaw_min))
            yaw = int'(settings.yaw_min);
         if (yaw >= int'(settings.yaw_max))
            yaw = int'(settings.yaw_max);
         yaw_pos = yaw[ANGLE_W-1:0];
         pitch = int'(pitch_pos);
         if (pitch <= PITCH_MIN)
            pitch = PITCH_MIN;
         if (pitch >= PITCH_MAX)
            pitch = PITCH_MAX;
         pitch_pos = pitch[ANGLE_W-1:0];
      end
      r.yaw_angle     = yaw_pos;
      r.pitch_angle   = pitch_pos;
      r.x_target_used = held_x_target;
      r.x_actual_used = held_x_actual;
      r.y_target_used = held_y_target;
      r.y_actual_used = held_y_actual;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic frame_in_type make_frame(int xt, int yt, int xa, int ya, bit stop);
      frame_in_type f;
      f.x_target = COORD_IN_W'(xt);
      f.y_target = COORD_IN_W'(yt);
      f.x_actual = COORD_IN_W'(xa);
      f.y_actual = COORD_IN_W'(ya);
      f.stop     = stop;
      return f;
   endfunction

   function automatic int in_range_coord(logic [COORD_W-1:0] limit);
      if (limit >= 2)
         return $urandom_range(1, int'(limit) - 1);
      return $urandom_range(0, 2);
   endfunction

   // Coordinates that the screening should mostly reject
   function automatic int noise_coord(logic [COORD_W-1:0] limit);
      case ($urandom_range(0, 4))
         0: return 0;
         1: return int'(limit);
         2: return -int'($urandom_range(1, 1000));
         3: return int'($urandom_range(0, 500)) + int'(limit);
         default: return $urandom;
      endcase
   endfunction

   function automatic int jitter_coord(int base, logic [COORD_W-1:0] limit);
      if ($urandom_range(0, 99) < 8)
         return noise_coord(limit);
      return base + int'($urandom_range(0, 4)) - 2;
   endfunction

   function automatic logic signed [GAIN_W-1:0] random_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return GAIN_W'($urandom_range(0, 1 << 23) - (1 << 22));
      if (r < 8)
         return GAIN_W'($urandom);
      return (r == 8) ? GAIN_MAX : GAIN_MIN;
   endfunction

   function automatic logic [COORD_W-1:0] random_coord_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return COORD_W'(1);
      if (r == 1)
         return COORD_LIMIT_MAX;
      return COORD_W'($urandom_range(2, int'(COORD_LIMIT_MAX)));
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int      r;
      int      a;
      int      b;
      c.prop_gain  = random_gain();
      c.integ_gain = random_gain();
      c.deriv_gain = random_gain();
      r = $urandom_range(0, 9);
      if (r < 2)
         c.integral_limit = '0;
      else if (r < 4)
         c.integral_limit = SUM_LIMIT_MAX;
      else
         c.integral_limit = LIMIT_W'($urandom_range(0, int'(SUM_LIMIT_MAX)));
      a = $urandom_range(0, int'(ANGLE_MAX));
      b = $urandom_range(0, int'(ANGLE_MAX));
      r = $urandom_range(0, 9);
      if (r < 2) begin
         c.yaw_min = '0;
         c.yaw_max = ANGLE_MAX;
      end else if (r < 4) begin
         // crossed bounds
         c.yaw_min = ANGLE_W'((a > b) ? a : b);
         c.yaw_max = ANGLE_W'((a > b) ? b : a);
      end else begin
         c.yaw_min = ANGLE_W'((a > b) ? b : a);
         c.yaw_max = ANGLE_W'((a > b) ? a : b);
      end
      c.x_limit = random_coord_limit();
      c.y_limit = random_coord_limit();
      return c;
   endfunction

   task automatic report_mismatch(string what, logic signed [31:0] got,
                                  logic signed [31:0] want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Offer one frame, hold it until the transaction completes, then predict
   task automatic send_frame(frame_in_type f);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.x_target <= f.x_target;
      req_if.y_target <= f.y_target;
      req_if.x_actual <= f.x_actual;
      req_if.y_actual <= f.y_actual;
      req_if.stop     <= f.stop;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_updates.push_back(servo_update(f));
   endtask

   // Drop valid and wait until every predicted update has been taken
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_updates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all registers on consecutive cycles; noisy fills unused data bits
   task automatic program_settings(cfg_type next, bit noisy);
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] pad;
      for (int i = 0; i < NUM_REGS; i++) begin
         pad = noisy ? CSR_DATA_W'($urandom) : '0;
         case (csr_index_type'(i))
            CSR_PROP_GAIN:      word = next.prop_gain;
            CSR_INTEG_GAIN:     word = next.integ_gain;
            CSR_DERIV_GAIN:     word = next.deriv_gain;
            CSR_INTEGRAL_LIMIT: word = {pad[CSR_DATA_W-1:LIMIT_W], next.integral_limit};
            CSR_YAW_MIN:        word = {pad[CSR_DATA_W-1:ANGLE_W], next.yaw_min};
            CSR_YAW_MAX:        word = {pad[CSR_DATA_W-1:ANGLE_W], next.yaw_max};
            CSR_X_LIMIT:        word = {pad[CSR_DATA_W-1:COORD_W], next.x_limit};
            default:            word = {pad[CSR_DATA_W-1:COORD_W], next.y_limit};
         endcase
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= word;
         @(posedge clock);
      end
      csr_we   <= 1'b0;
      settings = next;
   endtask

   // Reset register values: accepted and rejected coordinate edges
   task automatic test_default_settings();
      send_frame(make_frame(310, 200, 300, 210, 1'b0));
      send_frame(make_frame(619, 1, 1, 479, 1'b0));
      send_frame(make_frame(0, 480, 620, 0, 1'b0));
      send_frame(make_frame(-1, -32768, 32767, -2, 1'b0));
      send_frame(make_frame(-32768, 32767, -32768, 32767, 1'b0));
   endtask

   // Stopped frames: angles and PID state hold, screening still runs
   task automatic test_stop_hold();
      send_frame(make_frame(600, 400, 10, 20, 1'b1));
      send_frame(make_frame(8, 6, 5, 8, 1'b1));
   endtask

   // Zero limits: every coordinate is rejected
   task automatic test_zero_limits();
      cfg_type c;
      c = reset_settings();
      c.x_limit = '0;
      c.y_limit = '0;
      settle();
      program_settings(c, 1'b0);
      send_frame(make_frame(100, 100, 50, 50, 1'b0));
      send_frame(make_frame(300, 200, 1, 1, 1'b0));
   endtask

   // Crossed yaw bounds: the high bound wins
   task automatic test_crossed_yaw();
      cfg_type c;
      c = reset_settings();
      c.yaw_min = ANGLE_W'(2000);
      c.yaw_max = ANGLE_W'(1000);
      settle();
      program_settings(c, 1'b0);
      send_frame(make_frame(500, 100, 100, 300, 1'b0));
      send_frame(make_frame(400, 100, 100, 300, 1'b0));
   endtask

   // Full-scale gains: drive the integral up while yaw sits at its high bound
   task automatic test_gain_saturation();
      cfg_type c;
      c.prop_gain      = GAIN_MAX;
      c.integ_gain     = GAIN_MAX;
      c.deriv_gain     = GAIN_MAX;
      c.integral_limit = SUM_LIMIT_MAX;
      c.yaw_min        = '0;
      c.yaw_max        = ANGLE_MAX;
      c.x_limit        = COORD_LIMIT_MAX;
      c.y_limit        = COORD_LIMIT_MAX;
      settle();
      program_settings(c, 1'b0);
      repeat (SAT_FRAMES) send_frame(make_frame(1022, 1022, 1, 1, 1'b0));
   endtask

   // Random settings per phase; tracking runs with steady targets and noise
   task automatic test_random_settings();
      cfg_type c;
      int      run_left;
      int      base_xt;
      int      base_yt;
      int      base_xa;
      int      base_ya;
      for (int p = 0; p < NUM_PHASES; p++) begin
         c = random_settings();
         if (p == 0) begin
            c.prop_gain      = GAIN_MAX;
            c.integ_gain     = GAIN_MAX;
            c.deriv_gain     = GAIN_MAX;
            c.integral_limit = SUM_LIMIT_MAX;
         end else if (p == 1) begin
            c.prop_gain      = GAIN_MIN;
            c.integ_gain     = GAIN_MIN;
            c.deriv_gain     = GAIN_MIN;
            c.integral_limit = SUM_LIMIT_MAX;
         end
         settle();
         program_settings(c, 1'b1);
         no_idle  = (p % 4 == 2);
         run_left = 0;
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 60);
               base_xt  = in_range_coord(settings.x_limit);
               base_xa  = in_range_coord(settings.x_limit);
               base_yt  = in_range_coord(settings.y_limit);
               base_ya  = in_range_coord(settings.y_limit);
            end
            run_left--;
            send_frame(make_frame(jitter_coord(base_xt, settings.x_limit),
                                  jitter_coord(base_yt, settings.y_limit),
                                  jitter_coord(base_xa, settings.x_limit),
                                  jitter_coord(base_ya, settings.y_limit),
                                  $urandom_range(0, 9) == 0));
         end
      end
      no_idle = 1'b0;
   endtask

   // Response side: random stalls, none while no_idle is set
   initial begin
      rsp_if.ready <= 1'b0;
      ready_hold = 0;
      forever begin
         @(posedge clock);
         if (no_idle) begin
            rsp_if.ready <= 1'b1;
         end else if (ready_hold > 0) begin
            ready_hold--;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_if.ready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
         end else begin
            rsp_if.ready <= 1'b0;
            ready_hold = pick_gap();
         end
      end
   end

   // Compare each response transaction with the oldest predicted update
   initial begin : check_updates
      servo_out_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_updates.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_if.yaw_angle, 0);
            end else begin
               want = pending_updates.pop_front();
               if (rsp_if.yaw_angle !== want.yaw_angle)
                  report_mismatch("yaw_angle", rsp_if.yaw_angle, want.yaw_angle);
               if (rsp_if.pitch_angle !== want.pitch_angle)
                  report_mismatch("pitch_angle", rsp_if.pitch_angle, want.pitch_angle);
               if (rsp_if.correction !== want.correction)
                  report_mismatch("correction", rsp_if.correction, want.correction);
               if (rsp_if.x_target_used !== want.x_target_used)
                  report_mismatch("x_target_used", rsp_if.x_target_used, want.x_target_used);
               if (rsp_if.x_actual_used !== want.x_actual_used)
                  report_mismatch("x_actual_used", rsp_if.x_actual_used, want.x_actual_used);
               if (rsp_if.y_target_used !== want.y_target_used)
                  report_mismatch("y_target_used", rsp_if.y_target_used, want.y_target_used);
               if (rsp_if.y_actual_used !== want.y_actual_used)
                  report_mismatch("y_actual_used", rsp_if.y_actual_used, want.y_actual_used);
            end
         end
      end
   end

   // End the run when no transaction moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t ns: no transaction for %0d cycles, %0d updates outstanding",
               $time, WATCHDOG_LIMIT, pending_updates.size());
      $display("FAILURE");
      $finish;
   end

   // Test sequence
   initial begin
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_PROP_GAIN;
      csr_data        <= '0;
      req_if.valid    <= 1'b0;
      req_if.x_target <= '0;
      req_if.y_target <= '0;
      req_if.x_actual <= '0;
      req_if.y_actual <= '0;
      req_if.stop     <= 1'b0;
      settings      = reset_settings();
      held_x_target = '0;
      held_y_target = '0;
      held_x_actual = '0;
      held_y_actual = '0;
      error_sum     = 0;
      prior_err     = 0;
      yaw_pos       = ANGLE_W'(YAW_START);
      pitch_pos     = ANGLE_W'(PITCH_START);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_stop_hold();
      test_zero_limits();
      test_crossed_yaw();
      test_gain_saturation();
      test_random_settings();
      settle();

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
